// File: rtl/bmhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types, codes and the key compare for the binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int ENT_W = KEY_W + TAG_W;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0] tag_t;

    typedef struct packed {
        tag_t tag;
        key_t key;
    } entry_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_UP_RD,
        S_UP_EVAL,
        S_DN_RD,
        S_DN_EVAL,
        S_DONE
    } state_t;

    // a strictly below b; signed order by flipping the sign bits
    function automatic logic key_less(key_t a, key_t b, logic sgn);
        key_t fa;
        key_t fb;
        fa = a;
        fb = b;
        if (sgn) begin
            fa[KEY_W-1] = ~a[KEY_W-1];
            fb[KEY_W-1] = ~b[KEY_W-1];
        end
        return fa < fb;
    endfunction

endpackage

// File: rtl/bmhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue of key/tag entries held in one dual-read RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser: op, tdata: key, tag
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: status .. top_tag
//  cfg       in   cfg_we                          cfg_wdata: key_signed
//
//  One item at a time; a new item is taken only after the last one is done.
//  A push climbs until it reaches the root or a parent stops it. A pop moves
//  the last entry to the root and sinks it until it reaches a leaf or a child
//  stops it. Rejections and a pop of the last entry go straight to the result.
//  Reset clears the count, the key order and the output valid; not the RAM.
//  A waiting result does not block the next item, only its completion.
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
    parameter int  DEPTH   = 1024,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW      = $clog2(DEPTH + 1),
    localparam int RAW_W   = 2 * bmhq_pkg::KEY_W + 2 * bmhq_pkg::TAG_W + CW + 3,
    localparam int OUT_W   = ((RAW_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,     // key_signed
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [bmhq_pkg::ENT_W-1:0] s_axis_tdata,  // key, tag
    input  logic                       s_axis_tuser,  // op
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status, popped_key, popped_tag, count, top_valid, top_key, top_tag
    output logic [OUT_W-1:0]           m_axis_tdata
);

    import bmhq_pkg::*;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    pos_reg, pos_next;
    entry_t           mov_reg, mov_next;
    entry_t           root_reg;
    entry_t           popped_reg, popped_next;
    status_t          status_reg, status_next;
    logic             ksgn_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    raddr_a, raddr_b;
    entry_t           rdata_a, rdata_b;

    logic [AW+1:0]    left_w, right_w, cnt_w;
    logic [AW-1:0]    parent;
    logic             lv, rv, take_l, take_r;
    key_t             best_key;
    logic             s_acc;
    logic             top_valid;
    logic [RAW_W-1:0] out_raw;

    bmhq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign left_w  = {1'b0, pos_reg, 1'b1};
    assign right_w = left_w + (AW+2)'(1);
    assign cnt_w   = (AW+2)'(count_reg);
    assign parent  = AW'((pos_reg - AW'(1)) >> 1);

    assign lv       = left_w < cnt_w;
    assign rv       = right_w < cnt_w;
    assign take_l   = lv && key_less(mov_reg.key, rdata_a.key, ksgn_reg);
    assign best_key = take_l ? rdata_a.key : mov_reg.key;
    assign take_r   = rv && key_less(best_key, rdata_b.key, ksgn_reg);

    assign top_valid = (count_reg != '0);
    assign out_raw   = {top_valid ? root_reg.tag : tag_t'(0),
                        top_valid ? root_reg.key : key_t'(0),
                        top_valid, count_reg,
                        popped_reg.tag, popped_reg.key, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ksgn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                ksgn_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        mov_reg      <= mov_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        // mirror of the root entry
        if (ram_we && ram_waddr == '0) begin
            root_reg <= ram_wdata;
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        mov_next       = mov_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = mov_reg;
        raddr_a        = parent;
        raddr_b        = right_w[AW-1:0];

        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                raddr_a = AW'(count_reg - CW'(1));
                if (s_acc) begin
                    popped_next = '0;
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                    if (op_t'(s_axis_tuser) == OP_PUSH) begin
                        if (count_reg < CW'(DEPTH)) begin
                            mov_next   = entry_t'(s_axis_tdata);
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            popped_next = root_reg;
                            count_next  = count_reg - CW'(1);
                            if (count_reg != CW'(1)) begin
                                state_next = S_LAST;
                            end
                        end
                    end
                end
            end
            S_LAST: begin
                // last entry moves to the root
                mov_next   = rdata_a;
                pos_next   = '0;
                state_next = S_DN_RD;
            end
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_EVAL;
                end
            end
            S_UP_EVAL: begin
                ram_we = 1'b1;
                if (key_less(rdata_a.key, mov_reg.key, ksgn_reg)) begin
                    ram_wdata  = rdata_a;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_RD: begin
                raddr_a = left_w[AW-1:0];
                if (!lv) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_EVAL;
                end
            end
            S_DN_EVAL: begin
                ram_we = 1'b1;
                if (take_r) begin
                    ram_wdata  = rdata_b;
                    pos_next   = right_w[AW-1:0];
                    state_next = S_DN_RD;
                end else if (take_l) begin
                    ram_wdata  = rdata_a;
                    pos_next   = left_w[AW-1:0];
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'(out_raw);
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_axis_tuser == OP_PUSH && count_reg < CW'(DEPTH))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the count");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP_EVAL || state_reg == S_DN_EVAL)
        |-> (AW+2)'(pos_reg) < cnt_w)
        else $error("sift position outside the held entries");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished item not presented");

endmodule
